// File: sv/tbhp_pkg.sv
// Shared types and constants for the trailing band hedge position block.
// Holds the field widths, the price class codes and the sequencer microcode.
// Depends on nothing; every other file imports it.
package tbhp_pkg;

    localparam int VAL_W      = 48;
    localparam int DROP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;

    localparam logic [DROP_W-1:0] DROP_RESET = 16'd655;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_FRACTION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEDGE_SHORT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEDGE_LONG       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVERAGED_MARKET = 2'd3;

    typedef enum logic [1:0] {
        CLS_BELOW  = 2'd0,
        CLS_INSIDE = 2'd1,
        CLS_ABOVE  = 2'd2
    } price_class_t;

    // Datapath operation selected by one control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_BAND,
        OP_CLASS,
        OP_DIV,
        OP_POS
    } uop_t;

    // Jump conditions; the jump goes to the target, otherwise to the next step.
    typedef enum logic [1:0] {
        JC_NEVER,
        JC_NO_INPUT,
        JC_DIV_MORE,
        JC_OUT_BUSY
    } jcond_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_MUL   = 3'd1;
    localparam step_t STEP_BAND  = 3'd2;
    localparam step_t STEP_CLASS = 3'd3;
    localparam step_t STEP_DIV   = 3'd4;
    localparam step_t STEP_POS   = 3'd5;

    // When last is set, falling through returns to the idle step.
    typedef struct packed {
        uop_t   op;
        jcond_t cond;
        step_t  target;
        logic   last;
    } ctl_word_t;

    // Microcode program, one control word per step.
    function automatic ctl_word_t ucode_rom(input step_t step);
        ctl_word_t w;
        case (step)
            STEP_IDLE:  w = '{op: OP_LOAD,  cond: JC_NO_INPUT, target: STEP_IDLE, last: 1'b0};
            STEP_MUL:   w = '{op: OP_MUL,   cond: JC_NEVER,    target: STEP_IDLE, last: 1'b0};
            STEP_BAND:  w = '{op: OP_BAND,  cond: JC_NEVER,    target: STEP_IDLE, last: 1'b0};
            STEP_CLASS: w = '{op: OP_CLASS, cond: JC_NEVER,    target: STEP_IDLE, last: 1'b0};
            STEP_DIV:   w = '{op: OP_DIV,   cond: JC_DIV_MORE, target: STEP_DIV,  last: 1'b0};
            STEP_POS:   w = '{op: OP_POS,   cond: JC_OUT_BUSY, target: STEP_POS,  last: 1'b1};
            default:    w = '{op: OP_NOP,   cond: JC_NEVER,    target: STEP_IDLE, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

// File: sv/trailing_band_hedge_position.sv
// Top level of the trailing band hedge position block.
// A microcoded sequencer drives a band, classing and restoring division datapath.
// Depends on tbhp_pkg.
//
// Usage: one input word carries a price and the currency available for hedging,
// both unsigned fixed point with PRICE_FRAC_BITS fraction bits. Each accepted
// word yields exactly one output word with the hedge position, both band edges
// and the price class. Words move at a rising edge where valid is high and
// stall is low; in_stall and out_stall are driven by the receiving side.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) and is
// to be written only while the block is idle; the block does not enforce this.
// An input word is taken in the idle step, then the sequencer spends one
// step on the drop multiply, one on the band edges, one on classing, then
// the quotient step, which repeats and makes one bit a cycle in the
// restoring divider, and one step to update the position and load the
// output register. No new word is taken until the sequencer is back in
// the idle step. If the receiver stalls, the finished word waits in the
// output register and the sequencer holds in its last step until the
// previous word is taken. Reset empties the output register, unseeds the
// band, clears the position and restores the settings.
module trailing_band_hedge_position
    import tbhp_pkg::*;
#(
    parameter int PRICE_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [VAL_W-1:0]              price,
    input  logic [VAL_W-1:0]              currency_amount,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VAL_W-1:0]       hedge_position,
    output logic [VAL_W-1:0]              band_low,
    output logic [VAL_W-1:0]              band_high,
    output logic [1:0]                    price_class
);

    // The quotient has VAL_W integer dividend bits followed by the fraction bits.
    localparam int DIV_STEPS = VAL_W + PRICE_FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_STEPS - 1);

    // Sequencer.
    step_t     step_reg, step_next;
    ctl_word_t ctl;
    logic      jump;

    // Configuration registers.
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic              short_reg, short_next;
    logic              long_reg, long_next;
    logic              lev_reg, lev_next;

    // Block state kept between words.
    logic [VAL_W-1:0]        lower_reg, lower_next;
    logic [VAL_W-1:0]        upper_reg, upper_next;
    logic signed [VAL_W-1:0] pos_reg, pos_next;
    price_class_t            prev_cls_reg, prev_cls_next;

    // Working registers for the word in flight.
    logic [VAL_W-1:0]   price_reg, price_next;
    logic [VAL_W-1:0]   dvd_reg, dvd_next;
    logic [VAL_W-1:0]   drop_d_reg, drop_d_next;
    logic [VAL_W-1:0]   rem_reg, rem_next;
    logic [VAL_W-2:0]   quot_reg, quot_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    price_class_t       cls_reg, cls_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_pos_reg, out_pos_next;
    logic [VAL_W-1:0]        out_low_reg, out_low_next;
    logic [VAL_W-1:0]        out_high_reg, out_high_next;
    price_class_t            out_cls_reg, out_cls_next;

    // Datapath terms.
    logic                    accept_in;
    logic                    out_busy;
    logic [VAL_W+DROP_W-1:0] drop_prod;
    logic [VAL_W:0]          low_sum;
    logic [VAL_W-1:0]        low_t;
    logic [VAL_W-1:0]        high_t;
    logic                    seed;
    logic [VAL_W-1:0]        lo_seed, hi_seed;
    logic [VAL_W:0]          trial;
    logic                    trial_ge;
    logic [VAL_W:0]          trial_diff;
    logic signed [VAL_W-1:0] q_val;
    logic signed [VAL_W-1:0] pos_upd;

    assign ctl       = ucode_rom(step_reg);
    assign in_stall  = (ctl.op != OP_LOAD);
    assign accept_in = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;

    always_comb
    begin
        case (ctl.cond)
            JC_NEVER:    jump = 1'b0;
            JC_NO_INPUT: jump = !in_valid;
            JC_DIV_MORE: jump = (cnt_reg != '0);
            JC_OUT_BUSY: jump = out_busy;
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (jump)
            step_next = ctl.target;
        else if (ctl.last)
            step_next = STEP_IDLE;
        else
            step_next = step_reg + 1'b1;
    end

    // Drop distance: price times the Q0.16 fraction, fraction bits dropped.
    assign drop_prod = price_reg * drop_reg;

    // Band targets. The lower target saturates; the upper one cannot underflow
    // because the drop distance never exceeds the price.
    assign low_sum = {1'b0, price_reg} + {1'b0, drop_d_reg};
    assign low_t   = low_sum[VAL_W] ? VAL_MAX : low_sum[VAL_W-1:0];
    assign high_t  = price_reg - drop_d_reg;
    assign seed    = (lower_reg == '0) && (upper_reg == '0);
    assign lo_seed = seed ? price_reg : lower_reg;
    assign hi_seed = seed ? price_reg : upper_reg;

    // One restoring division step. A zero price makes every quotient bit one,
    // so the overflow flag alone gives the saturated result there.
    assign trial      = {rem_reg, dvd_reg[VAL_W-1]};
    assign trial_ge   = (trial >= {1'b0, price_reg});
    assign trial_diff = trial - {1'b0, price_reg};

    // Any quotient bit that left the top of quot_reg had weight 2^47 or more.
    assign q_val = ovf_reg ? $signed(POS_MAX) : $signed({1'b0, quot_reg});

    // Position update for the classed price.
    always_comb
    begin
        pos_upd = pos_reg;
        case (cls_reg)
            CLS_BELOW:
            begin
                if (pos_reg > 48'sd0)
                    pos_upd = '0;
            end
            CLS_ABOVE:
            begin
                if (pos_reg < 48'sd0)
                    pos_upd = '0;
                else if (!lev_reg && short_reg && (prev_cls_reg != CLS_ABOVE))
                    pos_upd = q_val;
            end
            CLS_INSIDE:
            begin
                if (prev_cls_reg == CLS_BELOW)
                begin
                    if (long_reg)
                        pos_upd = q_val;
                end
                else if (prev_cls_reg == CLS_ABOVE)
                begin
                    if (short_reg)
                        pos_upd = lev_reg ? -q_val : '0;
                end
            end
            default:
            begin
                pos_upd = pos_reg;
            end
        endcase
    end

    always_comb
    begin
        drop_next      = drop_reg;
        short_next     = short_reg;
        long_next      = long_reg;
        lev_next       = lev_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        pos_next       = pos_reg;
        prev_cls_next  = prev_cls_reg;
        price_next     = price_reg;
        dvd_next       = dvd_reg;
        drop_d_next    = drop_d_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        cls_next       = cls_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        out_cls_next   = out_cls_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DROP_FRACTION:    drop_next  = cfg_data;
                CFG_HEDGE_SHORT:      short_next = cfg_data[0];
                CFG_HEDGE_LONG:       long_next  = cfg_data[0];
                CFG_LEVERAGED_MARKET: lev_next   = cfg_data[0];
                default:              drop_next  = drop_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (ctl.op)
            OP_LOAD:
            begin
                if (accept_in)
                begin
                    price_next = price;
                    dvd_next   = currency_amount;
                    rem_next   = '0;
                    quot_next  = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = CNT_LOAD;
                end
            end
            OP_MUL:
            begin
                drop_d_next = drop_prod[VAL_W+DROP_W-1:DROP_W];
            end
            OP_BAND:
            begin
                lower_next = (lo_seed > low_t) ? low_t : lo_seed;
                upper_next = (hi_seed < high_t) ? high_t : hi_seed;
            end
            OP_CLASS:
            begin
                if (price_reg < lower_reg)
                    cls_next = CLS_BELOW;
                else if (price_reg > upper_reg)
                    cls_next = CLS_ABOVE;
                else
                    cls_next = CLS_INSIDE;
            end
            OP_DIV:
            begin
                rem_next  = trial_ge ? trial_diff[VAL_W-1:0] : trial[VAL_W-1:0];
                quot_next = {quot_reg[VAL_W-3:0], trial_ge};
                ovf_next  = ovf_reg | quot_reg[VAL_W-2];
                dvd_next  = {dvd_reg[VAL_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
            end
            OP_POS:
            begin
                // Commit only once the previous word has left the output register.
                if (!out_busy)
                begin
                    pos_next       = pos_upd;
                    prev_cls_next  = cls_reg;
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_upd;
                    out_low_next   = lower_reg;
                    out_high_next  = upper_reg;
                    out_cls_next   = cls_reg;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            drop_reg      <= DROP_RESET;
            short_reg     <= 1'b0;
            long_reg      <= 1'b0;
            lev_reg       <= 1'b0;
            lower_reg     <= '0;
            upper_reg     <= '0;
            pos_reg       <= '0;
            prev_cls_reg  <= CLS_INSIDE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            drop_reg      <= drop_next;
            short_reg     <= short_next;
            long_reg      <= long_next;
            lev_reg       <= lev_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            pos_reg       <= pos_next;
            prev_cls_reg  <= prev_cls_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        dvd_reg      <= dvd_next;
        drop_d_reg   <= drop_d_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        ovf_reg      <= ovf_next;
        cnt_reg      <= cnt_next;
        cls_reg      <= cls_next;
        out_pos_reg  <= out_pos_next;
        out_low_reg  <= out_low_next;
        out_high_reg <= out_high_next;
        out_cls_reg  <= out_cls_next;
    end

    assign out_valid      = out_valid_reg;
    assign hedge_position = out_pos_reg;
    assign band_low       = out_low_reg;
    assign band_high      = out_high_reg;
    assign price_class    = out_cls_reg;

endmodule

// File: sv/tbhp_checker.sv
// Port level checks for the trailing band hedge position block.
// Bound to the top level below; depends on tbhp_pkg.
module tbhp_checker
    import tbhp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [VAL_W-1:0] hedge_position,
    input logic [VAL_W-1:0]        band_low,
    input logic [VAL_W-1:0]        band_high,
    input logic [1:0]              price_class
);

    // A stalled output word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // One word at a time: the block is busy right after taking a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the word in flight finished");

    // A stalled output word keeps every field unchanged.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hedge_position) && $stable(band_low) &&
                                   $stable(band_high) && $stable(price_class))
        else $error("output word changed while stalled");

    // Once seeded, the lower edge never passes the upper edge.
    a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> band_low <= band_high)
        else $error("band edges crossed");

    // Below the band no long position remains; above it no short one.
    a_class_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((price_class != CLS_BELOW) || (hedge_position <= 48'sd0)) &&
                      ((price_class != CLS_ABOVE) || !hedge_position[VAL_W-1]))
        else $error("position sign does not fit the price class");

endmodule

bind trailing_band_hedge_position tbhp_checker u_tbhp_checker (.*);

// File: dv/hedge_band_monitor.sv
// Checker for the trailing band hedge position block: watches both channels and the
// register port, predicts every output word and compares it field by field.
// Depends on tbhp_pkg for widths, register indexes and the price class codes.
module hedge_band_monitor
    import tbhp_pkg::*;
#(
    parameter int PRICE_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [VAL_W-1:0]        price,
    input  logic [VAL_W-1:0]        currency_amount,

    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [VAL_W-1:0] hedge_position,
    input  logic [VAL_W-1:0]        band_low,
    input  logic [VAL_W-1:0]        band_high,
    input  logic [1:0]              price_class,

    output int                      mismatches,
    output int                      outstanding,
    output int                      words_checked,
    output int                      below_count,
    output int                      inside_count,
    output int                      above_count
);

    localparam int WIDE_W = VAL_W + PRICE_FRAC_BITS;

    typedef struct {
        logic signed [VAL_W-1:0] position;
        logic [VAL_W-1:0]        low;
        logic [VAL_W-1:0]        high;
        price_class_t            cls;
    } tick_result_t;

    logic [DROP_W-1:0]       drop_frac;
    logic                    short_on;
    logic                    long_on;
    logic                    lev_on;
    logic [VAL_W-1:0]        low_edge;
    logic [VAL_W-1:0]        high_edge;
    logic signed [VAL_W-1:0] held;
    price_class_t            prev_cls;
    tick_result_t            expected_ticks[$];

    task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
        $display("mismatch on word %0d, %s: got %h, expected %h",
                 words_checked, what, got, want);
        mismatches++;
    endtask

    // Moves the band, classes the price and updates the held position for one tick.
    task automatic advance_band(input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] cur);
        logic [VAL_W+DROP_W-1:0] prod;
        logic [VAL_W-1:0]        offset;
        logic [VAL_W:0]          lo_tgt;
        logic [VAL_W-1:0]        hi_tgt;
        logic [WIDE_W-1:0]       num;
        logic [WIDE_W-1:0]       quo;
        logic [VAL_W-1:0]        mag;
        price_class_t            cls;
        tick_result_t            r;
        prod   = px * drop_frac;
        offset = prod[VAL_W+DROP_W-1:DROP_W];
        lo_tgt = {1'b0, px} + {1'b0, offset};
        if (lo_tgt[VAL_W])
            lo_tgt = {1'b0, VAL_MAX};
        hi_tgt = px - offset;

        // The quotient saturates, and a zero price counts as the largest quotient.
        if (px == '0)
            mag = POS_MAX;
        else
        begin
            num = WIDE_W'(cur) << PRICE_FRAC_BITS;
            quo = num / WIDE_W'(px);
            mag = (quo > WIDE_W'(POS_MAX)) ? POS_MAX : quo[VAL_W-1:0];
        end

        if (low_edge == '0 && high_edge == '0)
        begin
            low_edge  = px;
            high_edge = px;
        end
        if (low_edge > lo_tgt[VAL_W-1:0])
            low_edge = lo_tgt[VAL_W-1:0];
        if (high_edge < hi_tgt)
            high_edge = hi_tgt;

        if (px < low_edge)
        begin
            cls = CLS_BELOW;
            if (held > 0)
                held = '0;
            below_count++;
        end
        else if (px > high_edge)
        begin
            cls = CLS_ABOVE;
            if (held < 0)
                held = '0;
            else if (!lev_on && short_on && prev_cls != CLS_ABOVE)
                held = mag;
            above_count++;
        end
        else
        begin
            cls = CLS_INSIDE;
            if (prev_cls == CLS_BELOW)
            begin
                if (long_on)
                    held = mag;
            end
            else if (prev_cls == CLS_ABOVE)
            begin
                if (short_on)
                    held = lev_on ? -$signed(mag) : '0;
            end
            inside_count++;
        end
        prev_cls = cls;

        r.position = held;
        r.low      = low_edge;
        r.high     = high_edge;
        r.cls      = cls;
        expected_ticks.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_result_t want;
        if (!rst_n)
        begin
            drop_frac     = DROP_RESET;
            short_on      = 1'b0;
            long_on       = 1'b0;
            lev_on        = 1'b0;
            low_edge      = '0;
            high_edge     = '0;
            held          = '0;
            prev_cls      = CLS_INSIDE;
            expected_ticks.delete();
            mismatches    = 0;
            outstanding   = 0;
            words_checked = 0;
            below_count   = 0;
            inside_count  = 0;
            above_count   = 0;
        end
        else
        begin
            // Results are taken before the new tick is queued, so a word leaving on
            // the same edge is matched against an older prediction.
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                    flag_mismatch("word with nothing expected", hedge_position, '0);
                else
                begin
                    want = expected_ticks.pop_front();
                    if (hedge_position !== want.position)
                        flag_mismatch("hedge_position", hedge_position, want.position);
                    if (band_low !== want.low)
                        flag_mismatch("band_low", band_low, want.low);
                    if (band_high !== want.high)
                        flag_mismatch("band_high", band_high, want.high);
                    if (price_class !== want.cls)
                        flag_mismatch("price_class", VAL_W'(price_class), VAL_W'(want.cls));
                end
                words_checked++;
            end
            if (in_valid && !in_stall)
                advance_band(price, currency_amount);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DROP_FRACTION:    drop_frac = cfg_data[DROP_W-1:0];
                    CFG_HEDGE_SHORT:      short_on  = cfg_data[0];
                    CFG_HEDGE_LONG:       long_on   = cfg_data[0];
                    CFG_LEVERAGED_MARKET: lev_on    = cfg_data[0];
                    default:              ;
                endcase
            end
            outstanding = expected_ticks.size();
        end
    end

endmodule

// File: dv/trailing_band_hedge_position_tb.sv
// Top of the testbench for the trailing band hedge position block: clock, reset,
// stimulus on both channels and the register port, and the final verdict.
// Depends on tbhp_pkg, the block itself and hedge_band_monitor.
module trailing_band_hedge_position_tb;
    import tbhp_pkg::*;

    // The final wait and the pause before register writes give the block room to
    // finish the words in flight.
    localparam int DRAIN_CYCLES = 100;
    localparam int CFG_SETTLE   = 4;
    localparam int LONG_HOLD    = 400;
    localparam int WALK_ITEMS   = 160;
    localparam int NOISE_ITEMS  = 170;
    localparam int RUN_LIMIT    = 12 * 2000000;

    localparam logic [VAL_W-1:0] SEED_PRICE = 48'h0000_4000_0000;
    localparam logic [VAL_W-1:0] UNIT_CASH  = 48'h0001_0000_0000;

    // How the next price relates to the prices seen so far.
    typedef enum logic [1:0] {
        MOVE_UP,
        MOVE_DOWN,
        MOVE_MID
    } move_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [VAL_W-1:0]        price;
    logic [VAL_W-1:0]        currency_amount;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [VAL_W-1:0] hedge_position;
    logic [VAL_W-1:0]        band_low;
    logic [VAL_W-1:0]        band_high;
    logic [1:0]              price_class;

    int mismatches;
    int outstanding;
    int words_checked;
    int below_count;
    int inside_count;
    int above_count;

    // Lowest and highest walk prices sent so far. Unless the drop distance is zero, a
    // price under the lowest one is below the band, and one over the highest is above it.
    logic [VAL_W-1:0] lo_seen;
    logic [VAL_W-1:0] hi_seen;
    move_t            last_move;
    bit               tx_calm;
    bit               rx_calm;
    int               hold_asks;
    int               hold_served;
    int               settings_count;

    trailing_band_hedge_position u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .price           (price),
        .currency_amount (currency_amount),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hedge_position  (hedge_position),
        .band_low        (band_low),
        .band_high       (band_high),
        .price_class     (price_class)
    );

    hedge_band_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .price           (price),
        .currency_amount (currency_amount),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hedge_position  (hedge_position),
        .band_low        (band_low),
        .band_high       (band_high),
        .price_class     (price_class),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .words_checked   (words_checked),
        .below_count     (below_count),
        .inside_count    (inside_count),
        .above_count     (above_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a word never arrives or the handshake locks up.
    initial
    begin
        #RUN_LIMIT;
        $display("Mismatches found");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then long enough to
    // land on any step of the processing loop.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 6);
        else if (r < 97)
            return $urandom_range(7, 40);
        else
            return $urandom_range(41, 150);
    endfunction

    function automatic logic [VAL_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[VAL_W-1:0];
    endfunction

    // Random value of random magnitude, so that both tiny and full width values
    // turn up; a quarter of the draws keep all 48 bits.
    function automatic logic [VAL_W-1:0] scaled48();
        int sh;
        sh = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, VAL_W - 1);
        return rand48() >> sh;
    endfunction

    // The receiver. It stalls at random, stays open during calm stretches, and
    // holds off for a long counted stretch whenever the stimulus asks for it.
    initial
    begin
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_served < hold_asks)
            begin
                out_stall <= 1'b1;
                hold_served++;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (rx_calm)
            begin
                out_stall <= 1'b0;
                @(negedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat (1 + pick_idle()) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (1 + pick_idle()) @(negedge clk);
            end
        end
    end

    // Offers one word and returns at the falling edge after it was taken. The
    // valid stays high on return so that back to back words need no gap.
    task automatic send_tick(input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] cur);
        int gap;
        gap = tx_calm ? 0 : pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        price           <= px;
        currency_amount <= cur;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Withdraws the valid and waits until every predicted word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Writes all four registers once the block has gone quiet. The flags are
    // sent with random upper bits, which the block must ignore.
    task automatic apply_settings(input logic [DROP_W-1:0] drop, input bit short_side,
                                  input bit long_side, input bit leveraged);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idx  [4];
        drain();
        repeat (CFG_SETTLE) @(negedge clk);
        idx[0]  = CFG_DROP_FRACTION;
        idx[1]  = CFG_HEDGE_SHORT;
        idx[2]  = CFG_HEDGE_LONG;
        idx[3]  = CFG_LEVERAGED_MARKET;
        vals[0] = drop;
        vals[1] = {15'($urandom), short_side};
        vals[2] = {15'($urandom), long_side};
        vals[3] = {15'($urandom), leveraged};
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_count++;
    endtask

    // Picks the next walk price. Up moves set new highs, down moves set new lows
    // unless the lowest price is two or less, and middle moves land anywhere between the two.
    task automatic next_walk_price(input move_t m, output logic [VAL_W-1:0] px);
        case (m)
            MOVE_UP:
                px = hi_seen + 1 + rand48() % ((hi_seen >> 6) + 1);
            MOVE_DOWN:
                if (lo_seen > 2)
                    px = lo_seen - 1 - rand48() % ((lo_seen >> 7) + 1);
                else
                    px = lo_seen + rand48() % (hi_seen - lo_seen + 1);
            default:
                px = lo_seen + rand48() % (hi_seen - lo_seen + 1);
        endcase
        if (px < lo_seen)
            lo_seen = px;
        if (px > hi_seen)
            hi_seen = px;
    endtask

    task automatic send_move(input move_t m, input logic [VAL_W-1:0] cur);
        logic [VAL_W-1:0] px;
        next_walk_price(m, px);
        last_move = m;
        send_tick(px, cur);
    endtask

    // Moves tend to repeat, so runs of new highs or new lows occur and the
    // class stays above or below for several ticks in a row.
    function automatic move_t pick_move();
        int r;
        if ($urandom_range(0, 1) == 0)
            return last_move;
        r = $urandom_range(0, 9);
        if (r < 3)
            return MOVE_UP;
        else if (r < 6)
            return MOVE_DOWN;
        else
            return MOVE_MID;
    endfunction

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_DROP_FRACTION;
        cfg_data        = '0;
        in_valid        = 1'b0;
        price           = '0;
        currency_amount = '0;
        lo_seen         = SEED_PRICE;
        hi_seen         = SEED_PRICE;
        last_move       = MOVE_MID;
        tx_calm         = 1'b0;
        rx_calm         = 1'b0;
        hold_asks       = 0;
        hold_served     = 0;
        settings_count  = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset settings. Zero prices leave
        // the band unseeded and take the saturated quotient; the first nonzero
        // word seeds both edges.
        send_tick('0, '0);
        send_tick('0, VAL_MAX);
        send_tick(SEED_PRICE, UNIT_CASH);

        // Both sides hedged, no leverage: a positive position on the first rise, flat after
        // the rise, long after a fall, and a long cleared by the next fall.
        apply_settings(DROP_RESET, 1'b1, 1'b1, 1'b0);
        send_move(MOVE_UP, UNIT_CASH);
        send_move(MOVE_UP, UNIT_CASH);
        send_move(MOVE_MID, UNIT_CASH);
        send_move(MOVE_DOWN, UNIT_CASH);
        send_move(MOVE_MID, UNIT_CASH);
        send_move(MOVE_DOWN, UNIT_CASH);
        send_move(MOVE_MID, UNIT_CASH);

        // Leveraged market: a rise no longer opens a position, the return into
        // the band goes negative, and a negative position survives a fall.
        apply_settings(DROP_RESET, 1'b1, 1'b1, 1'b1);
        send_move(MOVE_UP, UNIT_CASH);
        send_move(MOVE_MID, UNIT_CASH);
        send_move(MOVE_UP, UNIT_CASH);
        send_move(MOVE_MID, UNIT_CASH);
        send_move(MOVE_DOWN, UNIT_CASH);
        send_move(MOVE_MID, UNIT_CASH);

        // Long side off: the return after a fall keeps whatever is held.
        apply_settings(DROP_RESET, 1'b1, 1'b0, 1'b1);
        send_move(MOVE_DOWN, VAL_MAX);
        send_move(MOVE_MID, '0);

        // Random walk phases, each under its own settings. Phase 1 carries the
        // long receiver hold, phase 2 runs with no idling on either side, and
        // phase 3 pauses the sender until all words are back.
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: apply_settings(DROP_RESET, 1'b1, 1'b1, 1'b0);
                1: apply_settings('0, 1'b1, 1'b1, 1'b1);
                2: apply_settings('1, 1'b1, 1'b0, 1'b0);
                4: apply_settings(16'd3277, 1'b0, 1'b1, 1'b1);
                6: apply_settings(16'd1, 1'b1, 1'b1, 1'b1);
                default: apply_settings(DROP_W'($urandom), 1'($urandom),
                                        1'($urandom), 1'($urandom));
            endcase
            tx_calm = (phase == 2);
            rx_calm = (phase == 2);
            for (int i = 0; i < WALK_ITEMS; i++)
            begin
                if (phase == 1 && i == 40)
                    hold_asks++;
                if (phase == 3 && i == 60)
                    drain();
                send_move(pick_move(), scaled48());
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Closing phase with the widest drop. The extreme prices come last
        // because a zero price after seeding pins the lower edge at zero for
        // good; the largest price saturates the lower target.
        apply_settings('1, 1'b1, 1'b1, 1'b1);
        send_tick(48'h0000_0000_FFFF, VAL_MAX);
        send_tick(48'd1, VAL_MAX);
        send_tick(48'd1, '0);
        send_tick('0, VAL_MAX);
        send_tick(VAL_MAX, VAL_MAX);
        send_tick(VAL_MAX, '0);
        for (int i = 0; i < NOISE_ITEMS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_tick('0, scaled48());
            else
                send_tick(scaled48(), scaled48());
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d words over %0d register settings, including a long output hold",
                 words_checked, settings_count);
        $display("Predicted classes: %0d below, %0d inside, %0d above",
                 below_count, inside_count, above_count);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
